>>> rtl/lbev_pkg.sv
// ----------------------------------------------------------------------------
// lbev_pkg
// Shared constants, codes and controller/datapath types for the lidar
// bird's-eye-view grid builder.
// ----------------------------------------------------------------------------
package lbev_pkg;

  // grid geometry
  localparam int GRID_MAX   = 512;
  localparam int IDX_W      = $clog2(GRID_MAX);
  localparam int WID_W      = $clog2(GRID_MAX + 1);
  localparam int PIX_W      = 2 * IDX_W;
  localparam int SQ_W       = 2 * WID_W;
  localparam int ADDR_W     = PIX_W + 1;
  localparam int MEM_DEPTH  = 2 * GRID_MAX * GRID_MAX;

  // arithmetic constants
  localparam logic [16:0] ROOT_HALF_Q16 = 17'd46341;
  localparam logic [16:0] RECIP_25_Q17  = 17'd5243;
  localparam logic signed [39:0] RND_HALF = 40'sd32768;
  localparam logic signed [19:0] Z_LOW_Q10  = -20'sd2795;
  localparam logic signed [19:0] Z_HIGH_Q10 = 20'sd1300;
  localparam logic signed [31:0] Z_OFFSET_X100 = 32'sd279552;
  localparam logic [7:0] CODE_MAX = 8'd255;

  // register reset values
  localparam logic [9:0]  GRID_WIDTH_RST = 10'd512;
  localparam logic [15:0] BOUNDARY_RST   = 16'd51200;
  localparam logic [23:0] PPM_RST        = 24'd335544;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_ROTATE   = 3'd0,
    REG_BANK     = 3'd1,
    REG_WIDTH    = 3'd2,
    REG_BOUNDARY = 3'd3,
    REG_PPM      = 3'd4
  } cfg_reg_t;

  // request actions
  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_POINT = 2'd1,
    ACT_TABLE = 2'd2,
    ACT_READ  = 2'd3
  } act_t;

  // datapath step commands
  typedef enum logic [4:0] {
    OP_NONE,
    OP_SQ,
    OP_CLR,
    OP_RY,
    OP_RX,
    OP_CHK,
    OP_Y0,
    OP_Y1,
    OP_X0,
    OP_X1,
    OP_HC,
    OP_ADR,
    OP_RDPIX,
    OP_UPD,
    OP_TBLW,
    OP_RCMP,
    OP_RTBL,
    OP_ROUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   latch;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic in_range;
    logic slot_free;
  } dp_stat_t;

endpackage

>>> rtl/lbev_if.sv
// ----------------------------------------------------------------------------
// lbev_if
// Channel interfaces: request items, result items and register writes.
// ----------------------------------------------------------------------------
interface lbev_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         action;
  logic signed [19:0] coord_first;
  logic signed [19:0] coord_second;
  logic signed [19:0] point_height;
  logic [15:0]        point_intensity;
  logic [17:0]        pixel_index;
  logic [7:0]         table_index;
  logic [7:0]         table_value;

  modport source (output valid, action, coord_first, coord_second, point_height,
                  point_intensity, pixel_index, table_index, table_value,
                  input ready);
  modport sink (input valid, action, coord_first, coord_second, point_height,
                point_intensity, pixel_index, table_index, table_value,
                output ready);
endinterface

interface lbev_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_intensity;
  logic [7:0] out_height;
  logic [7:0] out_density;

  modport source (output valid, out_intensity, out_height, out_density, input ready);
  modport sink (input valid, out_intensity, out_height, out_density, output ready);
endinterface

interface lbev_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/lidar_points_to_bev_grid.sv
// ----------------------------------------------------------------------------
// lidar_points_to_bev_grid
// Bird's-eye-view grid builder for lidar points, two banks of 24-bit pixels.
// ----------------------------------------------------------------------------
// cmd takes one request per handshake: clear bank, point, table load or read.
// rsp returns one result for each read request, nothing for the others.
// cfg writes the five registers and is always ready; it is to be used while
// idle, a rule on the user that the block does not enforce. Requests run one
// at a time, sequencer and datapath sharing one 22x17 multiplier, in steps:
//   clear      : square W, then zero one pixel per cycle (W = grid width)
//   point      : rotate, check range (else dropped), project, update pixel
//   table load : one write to the density table
//   read       : square W, range compare, pixel and table reads, result out
// The result register decouples rsp: a stalled result holds, and other
// requests are still taken; a following read waits only in its last step.
// Reset returns the registers to their defaults and empties rsp; the pixel
// store and density table are undefined until cleared or written.
module lidar_points_to_bev_grid (
  input  logic          clk,
  input  logic          rst,
  lbev_in_if.sink       cmd,
  lbev_out_if.source    rsp,
  lbev_cfg_if.sink      cfg
);

  lbev_pkg::dp_cmd_t  dp_cmd;
  lbev_pkg::dp_stat_t dp_stat;

  assign cfg.ready = 1'b1;

  // sequencer
  lbev_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cmd.valid),
    .in_action (cmd.action),
    .in_ready  (cmd.ready),
    .cmd       (dp_cmd),
    .stat      (dp_stat)
  );

  // datapath
  lbev_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .coord_first     (cmd.coord_first),
    .coord_second    (cmd.coord_second),
    .point_height    (cmd.point_height),
    .point_intensity (cmd.point_intensity),
    .pixel_index     (cmd.pixel_index),
    .table_index     (cmd.table_index),
    .table_value     (cmd.table_value),
    .cfg_valid       (cfg.valid),
    .cfg_index       (cfg.index),
    .cfg_data        (cfg.data),
    .rsp_ready       (rsp.ready),
    .rsp_valid       (rsp.valid),
    .out_intensity   (rsp.out_intensity),
    .out_height      (rsp.out_height),
    .out_density     (rsp.out_density)
  );

endmodule

>>> rtl/lbev_ctrl.sv
// ----------------------------------------------------------------------------
// lbev_ctrl
// Sequencer: walks each request through the datapath steps of its action.
// ----------------------------------------------------------------------------
module lbev_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic [1:0]         in_action,
  output logic               in_ready,
  output lbev_pkg::dp_cmd_t  cmd,
  input  lbev_pkg::dp_stat_t stat
);

  typedef enum logic [4:0] {
    S_IDLE, S_SQC, S_CLR, S_RY, S_RX, S_CHK, S_Y0, S_Y1, S_X0, S_X1,
    S_HC, S_ADR, S_RDPIX, S_UPD, S_TBLW, S_SQR, S_RCMP, S_RTBL, S_ROUT
  } state_t;

  state_t state;

  assign in_ready = (state == S_IDLE);

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            case (lbev_pkg::act_t'(in_action))
              lbev_pkg::ACT_CLEAR: state <= S_SQC;
              lbev_pkg::ACT_POINT: state <= S_RY;
              lbev_pkg::ACT_TABLE: state <= S_TBLW;
              lbev_pkg::ACT_READ:  state <= S_SQR;
              default:             state <= S_IDLE;
            endcase
          end
        end
        S_SQC:   state <= S_CLR;
        S_CLR:   if (stat.clr_last) state <= S_IDLE;
        S_RY:    state <= S_RX;
        S_RX:    state <= S_CHK;
        S_CHK:   state <= S_Y0;
        S_Y0:    state <= stat.in_range ? S_Y1 : S_IDLE;
        S_Y1:    state <= S_X0;
        S_X0:    state <= S_X1;
        S_X1:    state <= S_HC;
        S_HC:    state <= S_ADR;
        S_ADR:   state <= S_RDPIX;
        S_RDPIX: state <= S_UPD;
        S_UPD:   state <= S_IDLE;
        S_TBLW:  state <= S_IDLE;
        S_SQR:   state <= S_RCMP;
        S_RCMP:  state <= S_RTBL;
        S_RTBL:  state <= S_ROUT;
        S_ROUT:  if (stat.slot_free) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // step command for the datapath
  always_comb begin
    cmd.latch = in_valid && (state == S_IDLE);
    case (state)
      S_SQC, S_SQR: cmd.op = lbev_pkg::OP_SQ;
      S_CLR:   cmd.op = lbev_pkg::OP_CLR;
      S_RY:    cmd.op = lbev_pkg::OP_RY;
      S_RX:    cmd.op = lbev_pkg::OP_RX;
      S_CHK:   cmd.op = lbev_pkg::OP_CHK;
      S_Y0:    cmd.op = lbev_pkg::OP_Y0;
      S_Y1:    cmd.op = lbev_pkg::OP_Y1;
      S_X0:    cmd.op = lbev_pkg::OP_X0;
      S_X1:    cmd.op = lbev_pkg::OP_X1;
      S_HC:    cmd.op = lbev_pkg::OP_HC;
      S_ADR:   cmd.op = lbev_pkg::OP_ADR;
      S_RDPIX: cmd.op = lbev_pkg::OP_RDPIX;
      S_UPD:   cmd.op = lbev_pkg::OP_UPD;
      S_TBLW:  cmd.op = lbev_pkg::OP_TBLW;
      S_RCMP:  cmd.op = lbev_pkg::OP_RCMP;
      S_RTBL:  cmd.op = lbev_pkg::OP_RTBL;
      S_ROUT:  cmd.op = stat.slot_free ? lbev_pkg::OP_ROUT : lbev_pkg::OP_NONE;
      default: cmd.op = lbev_pkg::OP_NONE;
    endcase
  end

endmodule

>>> rtl/lbev_dp.sv
// ----------------------------------------------------------------------------
// lbev_dp
// Datapath: configuration registers, shared multiplier, projection, pixel
// store, density table and result register.
// ----------------------------------------------------------------------------
module lbev_dp (
  input  logic               clk,
  input  logic               rst,
  input  lbev_pkg::dp_cmd_t  cmd,
  output lbev_pkg::dp_stat_t stat,
  input  logic signed [19:0] coord_first,
  input  logic signed [19:0] coord_second,
  input  logic signed [19:0] point_height,
  input  logic [15:0]        point_intensity,
  input  logic [17:0]        pixel_index,
  input  logic [7:0]         table_index,
  input  logic [7:0]         table_value,
  input  logic               cfg_valid,
  input  logic [2:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic               rsp_ready,
  output logic               rsp_valid,
  output logic [7:0]         out_intensity,
  output logic [7:0]         out_height,
  output logic [7:0]         out_density
);

  localparam int IDX_W  = lbev_pkg::IDX_W;
  localparam int WID_W  = lbev_pkg::WID_W;
  localparam int PIX_W  = lbev_pkg::PIX_W;
  localparam int SQ_W   = lbev_pkg::SQ_W;
  localparam int ADDR_W = lbev_pkg::ADDR_W;

  // configuration
  logic        rotate_45;
  logic        buffer_bank;
  logic [9:0]  grid_width;
  logic [15:0] boundary;
  logic [23:0] pixels_per_meter;

  // latched request
  logic signed [19:0] c0, c1, z;
  logic [15:0]        inten;
  logic [17:0]        pix;
  logic [7:0]         tidx, tval;

  // working registers
  logic signed [39:0] prod, acc;
  logic signed [20:0] y, x;
  logic [12:0]        t;
  logic [IDX_W-1:0]   iy, ix;
  logic [7:0]         hc;
  logic [PIX_W-1:0]   cnt;
  logic [PIX_W-1:0]   upd_addr;
  logic               rd_outside;
  logic [23:0]        rdata;
  logic [7:0]         tdata;

  // memories
  logic [23:0] pix_mem [lbev_pkg::MEM_DEPTH];
  logic [7:0]  dens_mem [256];

  logic [WID_W-1:0]   w;
  logic signed [21:0] mul_a;
  logic [16:0]        mul_b;
  logic               mul_en;
  logic signed [39:0] rnd;
  logic signed [47:0] proj_v;
  logic signed [21:0] y22, x22, b22;
  logic signed [31:0] zn;
  logic [31:0]        zn255;
  logic [23:0]        ic_full;
  logic [PIX_W-1:0]   pt_addr;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr, mem_raddr;
  logic [23:0]        mem_wdata;
  logic               mem_re;
  logic [7:0]         new_cnt;
  logic               higher;

  function automatic logic [IDX_W-1:0] proj(input logic signed [47:0] v,
                                            input logic [WID_W-1:0] wd);
    logic [21:0]      q;
    logic [IDX_W-1:0] r;
    q = v[47:26];
    if (v[47]) begin
      r = '0;
    end else if (32'(q) > 32'(wd) - 32'd1) begin
      r = IDX_W'(wd - WID_W'(1));
    end else begin
      r = IDX_W'(q);
    end
    return r;
  endfunction

  // effective grid width
  always_comb begin
    if (grid_width == 10'd0) begin
      w = WID_W'(1);
    end else if (32'(grid_width) > lbev_pkg::GRID_MAX) begin
      w = WID_W'(lbev_pkg::GRID_MAX);
    end else begin
      w = WID_W'(grid_width);
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rotate_45        <= 1'b0;
      buffer_bank      <= 1'b0;
      grid_width       <= lbev_pkg::GRID_WIDTH_RST;
      boundary         <= lbev_pkg::BOUNDARY_RST;
      pixels_per_meter <= lbev_pkg::PPM_RST;
    end else if (cfg_valid) begin
      case (lbev_pkg::cfg_reg_t'(cfg_index))
        lbev_pkg::REG_ROTATE:   rotate_45        <= cfg_data[0];
        lbev_pkg::REG_BANK:     buffer_bank      <= cfg_data[0];
        lbev_pkg::REG_WIDTH:    grid_width       <= cfg_data[9:0];
        lbev_pkg::REG_BOUNDARY: boundary         <= cfg_data[15:0];
        lbev_pkg::REG_PPM:      pixels_per_meter <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    case (cmd.op)
      lbev_pkg::OP_SQ: begin
        mul_a = 22'(w);
        mul_b = 17'(w);
      end
      lbev_pkg::OP_RY: begin
        mul_a = 22'(c1) + 22'(c0);
        mul_b = lbev_pkg::ROOT_HALF_Q16;
      end
      lbev_pkg::OP_RX: begin
        mul_a = 22'(c1) - 22'(c0);
        mul_b = lbev_pkg::ROOT_HALF_Q16;
      end
      lbev_pkg::OP_Y0: begin
        mul_a = 22'(y);
        mul_b = 17'(pixels_per_meter[11:0]);
      end
      lbev_pkg::OP_Y1: begin
        mul_a = 22'(y);
        mul_b = 17'(pixels_per_meter[23:12]);
      end
      lbev_pkg::OP_X0: begin
        mul_a = 22'(x);
        mul_b = 17'(pixels_per_meter[11:0]);
      end
      lbev_pkg::OP_X1: begin
        mul_a = 22'(x);
        mul_b = 17'(pixels_per_meter[23:12]);
      end
      lbev_pkg::OP_HC: begin
        mul_a = 22'(t);
        mul_b = lbev_pkg::RECIP_25_Q17;
      end
      lbev_pkg::OP_ADR: begin
        mul_a = 22'(iy);
        mul_b = 17'(w);
      end
      default: mul_en = 1'b0;
    endcase
  end

  // rounding, projection sum and range check
  assign rnd    = prod + lbev_pkg::RND_HALF;
  assign proj_v = (48'(prod) <<< 12) + 48'(acc) + (48'(w >> 1) << 26);
  assign y22    = 22'(y);
  assign x22    = 22'(x);
  assign b22    = $signed({6'b0, boundary});
  assign zn     = 32'(z) * 32'sd100 + lbev_pkg::Z_OFFSET_X100;
  assign zn255  = 32'(zn) * 32'd255;
  assign ic_full = {inten, 8'b0} - {8'b0, inten};
  assign pt_addr = PIX_W'(prod[SQ_W-1:0]) + PIX_W'(ix);

  assign stat.in_range  = (y22 > -b22) && (y22 < b22) && (x22 > -b22) && (x22 < b22) &&
                          (z >= lbev_pkg::Z_LOW_Q10) && (z <= lbev_pkg::Z_HIGH_Q10);
  assign stat.clr_last  = (32'(cnt) == 32'(prod[SQ_W-1:0]) - 32'd1);
  assign stat.slot_free = !rsp_valid || rsp_ready;

  // request latch and step registers
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      c0    <= coord_first;
      c1    <= coord_second;
      z     <= point_height;
      inten <= point_intensity;
      pix   <= pixel_index;
      tidx  <= table_index;
      tval  <= table_value;
    end
    if (mul_en) begin
      prod <= 40'(mul_a * $signed({1'b0, mul_b}));
    end
    case (cmd.op)
      lbev_pkg::OP_SQ:  cnt <= '0;
      lbev_pkg::OP_CLR: cnt <= cnt + PIX_W'(1);
      lbev_pkg::OP_RX:  y <= rotate_45 ? rnd[36:16] : 21'(c0);
      lbev_pkg::OP_CHK: begin
        x <= rotate_45 ? rnd[36:16] : 21'(c1);
        t <= zn255[26:14];
      end
      lbev_pkg::OP_Y1:    acc <= prod;
      lbev_pkg::OP_X0:    iy <= proj(proj_v, w);
      lbev_pkg::OP_X1:    acc <= prod;
      lbev_pkg::OP_HC:    ix <= proj(proj_v, w);
      lbev_pkg::OP_ADR:   hc <= prod[24:17];
      lbev_pkg::OP_RDPIX: upd_addr <= pt_addr;
      lbev_pkg::OP_RCMP:  rd_outside <= (32'(pix) >= 32'(prod[SQ_W-1:0]));
      default: ;
    endcase
  end

  // pixel update value
  assign higher  = hc > rdata[15:8];
  assign new_cnt = (rdata[7:0] < lbev_pkg::CODE_MAX) ? rdata[7:0] + 8'd1 : rdata[7:0];

  // pixel store port select
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {buffer_bank, cnt};
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = {buffer_bank, pt_addr};
    case (cmd.op)
      lbev_pkg::OP_CLR: mem_we = 1'b1;
      lbev_pkg::OP_UPD: begin
        mem_we    = 1'b1;
        mem_waddr = {buffer_bank, upd_addr};
        mem_wdata = {higher ? ic_full[23:16] : rdata[23:16],
                     higher ? hc : rdata[15:8], new_cnt};
      end
      lbev_pkg::OP_RDPIX: mem_re = 1'b1;
      lbev_pkg::OP_RCMP: begin
        mem_re    = 1'b1;
        mem_raddr = {buffer_bank, PIX_W'(pix)};
      end
      default: ;
    endcase
  end

  // pixel store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      pix_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata <= pix_mem[mem_raddr];
    end
  end

  // density table
  always_ff @(posedge clk) begin
    if (cmd.op == lbev_pkg::OP_TBLW) begin
      dens_mem[tidx] <= tval;
    end
    if (cmd.op == lbev_pkg::OP_RTBL) begin
      tdata <= dens_mem[rdata[7:0]];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.op == lbev_pkg::OP_ROUT) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
    if (cmd.op == lbev_pkg::OP_ROUT) begin
      out_intensity <= rd_outside ? 8'd0 : rdata[23:16];
      out_height    <= rd_outside ? 8'd0 : rdata[15:8];
      out_density   <= rd_outside ? 8'd0 : tdata;
    end
  end

endmodule

>>> rtl/lbev_check.sv
// ----------------------------------------------------------------------------
// lbev_check
// Port-level checks for the bird's-eye-view grid builder, bound to the top.
// ----------------------------------------------------------------------------
module lbev_check (
  input logic       clk,
  input logic       rst,
  input logic       cmd_valid,
  input logic       cmd_ready,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_intensity,
  input logic [7:0] rsp_height,
  input logic [7:0] rsp_density
);

  // stalled result stays
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped while stalled");

  // stalled result payload holds
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> $stable(rsp_intensity) && $stable(rsp_height) &&
                                $stable(rsp_density))
    else $error("result payload changed while stalled");

  // one request at a time
  a_one_req: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && cmd_ready |=> !cmd_ready)
    else $error("request taken while busy");

  // a new result follows a busy cycle
  a_rsp_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(!cmd_ready))
    else $error("result without a read in progress");

  // reset empties the result slot
  a_rst_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

endmodule

bind lidar_points_to_bev_grid lbev_check u_lbev_check (
  .clk           (clk),
  .rst           (rst),
  .cmd_valid     (cmd.valid),
  .cmd_ready     (cmd.ready),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_intensity (rsp.out_intensity),
  .rsp_height    (rsp.out_height),
  .rsp_density   (rsp.out_density)
);

>>> tb/lidar_points_to_bev_grid_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_points_to_bev_grid_tb
// Drives clear, point, table-load and read requests through several register
// settings, predicts every pixel update in a local copy of both banks and
// the density table, and checks each read result field by field.
// ----------------------------------------------------------------------------
module lidar_points_to_bev_grid_tb;

  localparam int BANK_SIZE  = lbev_pkg::GRID_MAX * lbev_pkg::GRID_MAX;
  localparam int IDLE_LIMIT = 1200000;

  typedef struct {
    lbev_pkg::act_t     action;
    logic signed [19:0] c0;
    logic signed [19:0] c1;
    logic signed [19:0] z;
    logic [15:0]        inten;
    logic [17:0]        pix;
    logic [7:0]         tidx;
    logic [7:0]         tval;
  } bev_req_t;

  typedef struct {
    logic [7:0] inten;
    logic [7:0] hgt;
    logic [7:0] dens;
  } pixel_res_t;

  logic clk;
  logic rst;

  lbev_in_if  cmd_if ();
  lbev_out_if rsp_if ();
  lbev_cfg_if cfg_if ();

  lidar_points_to_bev_grid dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if.sink),
    .rsp (rsp_if.source),
    .cfg (cfg_if.sink)
  );

  // predicted block state
  logic [7:0]  grid_int [2*BANK_SIZE];
  logic [7:0]  grid_hgt [2*BANK_SIZE];
  logic [7:0]  grid_cnt [2*BANK_SIZE];
  logic [7:0]  dens_lut [256];
  logic        cfg_rot;
  logic        cfg_bank;
  logic [9:0]  cfg_width;
  logic [15:0] cfg_bound;
  logic [23:0] cfg_ppm;

  bev_req_t   req_q [$];
  pixel_res_t pixel_results_q [$];
  bev_req_t   cur_req;
  int         err_cnt;
  bit         quiet;
  int         src_gap;
  int         snk_stall;
  int         idle_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic longint used_width();
    if (cfg_width == 0) return 1;
    if (cfg_width > lbev_pkg::GRID_MAX) return lbev_pkg::GRID_MAX;
    return longint'(cfg_width);
  endfunction

  function automatic longint grid_cell(longint c, longint w);
    longint v;
    v = c * longint'(cfg_ppm) + ((w / 2) <<< 26);
    if (v < 0) return 0;
    v = v >>> 26;
    return (v > w - 1) ? w - 1 : v;
  endfunction

  // update predicted state for one accepted request
  function automatic void apply_request(bev_req_t r);
    longint w, base, y, x, b, zz, a, hc, ic;
    pixel_res_t res;
    w = used_width();
    base = cfg_bank ? BANK_SIZE : 0;
    case (r.action)
      lbev_pkg::ACT_CLEAR: begin
        for (longint i = 0; i < w * w; i++) begin
          grid_int[base+i] = 8'd0;
          grid_hgt[base+i] = 8'd0;
          grid_cnt[base+i] = 8'd0;
        end
      end
      lbev_pkg::ACT_POINT: begin
        if (cfg_rot) begin
          y = ((longint'(r.c1) + longint'(r.c0)) * 46341 + 32768) >>> 16;
          x = ((longint'(r.c1) - longint'(r.c0)) * 46341 + 32768) >>> 16;
        end else begin
          y = longint'(r.c0);
          x = longint'(r.c1);
        end
        b = longint'(cfg_bound);
        zz = longint'(r.z);
        if (y > -b && y < b && x > -b && x < b && zz >= -2795 && zz <= 1300) begin
          a = base + grid_cell(x, w) + grid_cell(y, w) * w;
          hc = ((zz * 100 + 279552) * 255) / 409600;
          ic = (longint'(r.inten) * 255) >>> 16;
          if (hc > longint'(grid_hgt[a])) begin
            grid_hgt[a] = hc[7:0];
            grid_int[a] = ic[7:0];
          end
          if (grid_cnt[a] < 8'd255) grid_cnt[a] = grid_cnt[a] + 8'd1;
        end
      end
      lbev_pkg::ACT_TABLE: dens_lut[r.tidx] = r.tval;
      default: begin
        if (longint'(r.pix) >= w * w) begin
          res = '{8'd0, 8'd0, 8'd0};
        end else begin
          a = base + longint'(r.pix);
          res = '{grid_int[a], grid_hgt[a], dens_lut[grid_cnt[a]]};
        end
        pixel_results_q.push_back(res);
      end
    endcase
  endfunction

  // request driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_if.valid <= 1'b0;
      src_gap <= 0;
    end else begin
      if (cmd_if.valid && cmd_if.ready) apply_request(cur_req);
      if (!cmd_if.valid || cmd_if.ready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          cmd_if.valid <= 1'b0;
        end else if (req_q.size() != 0 && (quiet || $urandom_range(0, 5) != 0)) begin
          cur_req = req_q.pop_front();
          cmd_if.valid           <= 1'b1;
          cmd_if.action          <= cur_req.action;
          cmd_if.coord_first     <= cur_req.c0;
          cmd_if.coord_second    <= cur_req.c1;
          cmd_if.point_height    <= cur_req.z;
          cmd_if.point_intensity <= cur_req.inten;
          cmd_if.pixel_index     <= cur_req.pix;
          cmd_if.table_index     <= cur_req.tidx;
          cmd_if.table_value     <= cur_req.tval;
        end else begin
          if (!quiet && $urandom_range(0, 7) == 0) src_gap <= int'($urandom_range(1, 16));
          cmd_if.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor and sink stalls
  always @(posedge clk) begin
    pixel_res_t exp_res;
    if (rst) begin
      rsp_if.ready <= 1'b0;
      snk_stall <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (pixel_results_q.size() == 0) begin
          $error("read result with no read pending");
          err_cnt++;
        end else begin
          exp_res = pixel_results_q.pop_front();
          if (rsp_if.out_intensity !== exp_res.inten) begin
            $error("out_intensity expected %0d actual %0d", exp_res.inten,
                   rsp_if.out_intensity);
            err_cnt++;
          end
          if (rsp_if.out_height !== exp_res.hgt) begin
            $error("out_height expected %0d actual %0d", exp_res.hgt, rsp_if.out_height);
            err_cnt++;
          end
          if (rsp_if.out_density !== exp_res.dens) begin
            $error("out_density expected %0d actual %0d", exp_res.dens,
                   rsp_if.out_density);
            err_cnt++;
          end
        end
      end
      if (quiet) begin
        rsp_if.ready <= 1'b1;
      end else if (snk_stall > 0) begin
        snk_stall <= snk_stall - 1;
        rsp_if.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
        snk_stall <= int'($urandom_range(1, 16));
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(lbev_pkg::cfg_reg_t idx, logic [23:0] data);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      lbev_pkg::REG_ROTATE:   cfg_rot   = data[0];
      lbev_pkg::REG_BANK:     cfg_bank  = data[0];
      lbev_pkg::REG_WIDTH:    cfg_width = data[9:0];
      lbev_pkg::REG_BOUNDARY: cfg_bound = data[15:0];
      default:                cfg_ppm   = data;
    endcase
  endtask

  task automatic wait_drained();
    while (req_q.size() != 0 || cmd_if.valid || pixel_results_q.size() != 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic bev_req_t blank_req(lbev_pkg::act_t act);
    bev_req_t r;
    r.action = act;
    r.c0 = 20'($urandom); r.c1 = 20'($urandom); r.z = 20'($urandom);
    r.inten = 16'($urandom); r.pix = 18'($urandom);
    r.tidx = 8'($urandom); r.tval = 8'($urandom);
    return r;
  endfunction

  function automatic void push_point(int c0, int c1, int z, int inten);
    bev_req_t r;
    r = blank_req(lbev_pkg::ACT_POINT);
    r.c0 = c0[19:0]; r.c1 = c1[19:0]; r.z = z[19:0]; r.inten = inten[15:0];
    req_q.push_back(r);
  endfunction

  function automatic void push_read(int p);
    bev_req_t r;
    r = blank_req(lbev_pkg::ACT_READ);
    r.pix = p[17:0];
    req_q.push_back(r);
  endfunction

  function automatic int in_bound_coord();
    int b;
    b = int'(cfg_bound);
    return int'($urandom_range(0, 2 * b - 2)) - (b - 1);
  endfunction

  // random requests; points mostly in range so pixels fill and counts climb
  function automatic void push_random(int n);
    longint w;
    int sel, c0, c1, z;
    w = used_width();
    for (int i = 0; i < n; i++) begin
      sel = int'($urandom_range(0, 99));
      if (sel < 60) begin
        c0 = ($urandom_range(0, 9) == 0) ? int'($urandom) : in_bound_coord();
        c1 = ($urandom_range(0, 9) == 0) ? int'($urandom) : in_bound_coord();
        z = ($urandom_range(0, 9) == 0) ? int'($urandom) :
            int'($urandom_range(0, 4095)) - 2795;
        push_point(c0, c1, z, int'($urandom));
      end else if (sel < 68) begin
        req_q.push_back(blank_req(lbev_pkg::ACT_TABLE));
      end else if (sel < 70 && w <= 64) begin
        req_q.push_back(blank_req(lbev_pkg::ACT_CLEAR));
      end else if ($urandom_range(0, 9) == 0) begin
        push_read(int'($urandom));
      end else begin
        push_read(int'($urandom_range(0, int'(w * w) - 1)));
      end
    end
    push_read(int'($urandom_range(0, int'(w * w) - 1)));
  endfunction

  // one register setting: write all registers, clear the bank, then traffic
  task automatic run_setting(logic rot, logic bank, logic [9:0] w, logic [15:0] b,
                             logic [23:0] ppm, int n, bit directed);
    longint ww;
    int bi;
    write_reg(lbev_pkg::REG_ROTATE, 24'(rot));
    write_reg(lbev_pkg::REG_BANK, 24'(bank));
    write_reg(lbev_pkg::REG_WIDTH, 24'(w));
    write_reg(lbev_pkg::REG_BOUNDARY, 24'(b));
    write_reg(lbev_pkg::REG_PPM, ppm);
    ww = used_width();
    bi = int'(b);
    req_q.push_back(blank_req(lbev_pkg::ACT_CLEAR));
    if (directed) begin
      // coordinate, height and intensity extremes, boundary edges, odd reads
      push_point(0, 0, 0, 16'hFFFF);
      push_point(0, 0, -2795, 0);
      push_point(0, 0, 1300, 16'hFFFF);
      push_point(0, 0, -2796, 16'h1234);
      push_point(0, 0, 1301, 16'h1234);
      push_point(bi - 1, -(bi - 1), 500, 16'h8000);
      push_point(-(bi - 1), bi - 1, 600, 16'h7FFF);
      push_point(bi, 0, 0, 16'hFFFF);
      push_point(0, -bi, 0, 16'hFFFF);
      push_point(524287, -524288, -524288, 16'hFFFF);
      push_point(-524288, 524287, 524287, 0);
      push_point(-1, -1, -1, 16'hAAAA);
      push_read(0);
      push_read(int'(ww * ww) - 1);
      push_read(int'(ww * ww / 2 + ww / 2));
      push_read(int'(ww * ww));
      push_read(18'h3FFFF);
      req_q.push_back(blank_req(lbev_pkg::ACT_TABLE));
      push_read(int'(ww * ww / 2 + ww / 2));
    end
    push_random(n);
    wait_drained();
  endtask

  initial begin
    bev_req_t r;
    err_cnt = 0;
    quiet = 1'b0;
    cmd_if.valid = 1'b0;
    cmd_if.action = lbev_pkg::ACT_CLEAR;
    cmd_if.coord_first = '0;
    cmd_if.coord_second = '0;
    cmd_if.point_height = '0;
    cmd_if.point_intensity = '0;
    cmd_if.pixel_index = '0;
    cmd_if.table_index = '0;
    cmd_if.table_value = '0;
    rsp_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = lbev_pkg::REG_ROTATE;
    cfg_if.data = '0;
    cfg_rot = 1'b0;
    cfg_bank = 1'b0;
    cfg_width = lbev_pkg::GRID_WIDTH_RST;
    cfg_bound = lbev_pkg::BOUNDARY_RST;
    cfg_ppm = lbev_pkg::PPM_RST;
    rst = 1'b1;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // fill the whole density table before any read
    for (int i = 0; i < 256; i++) begin
      r = blank_req(lbev_pkg::ACT_TABLE);
      r.tidx = i[7:0];
      req_q.push_back(r);
    end
    wait_drained();

    run_setting(1'b0, 1'b0, 10'd512, 16'd51200, 24'd335544, 180, 1'b1);
    run_setting(1'b1, 1'b1, 10'd16, 16'd65535, 24'hFFFFFF, 250, 1'b1);
    run_setting(1'b0, 1'b1, 10'd0, 16'd1, 24'd1, 150, 1'b0);
    run_setting(1'b1, 1'b0, 10'd1, 16'd30000, 24'd100000, 200, 1'b0);
    run_setting(1'b0, 1'b0, 10'd700, 16'd20000, 24'd838861, 120, 1'b0);
    quiet = 1'b1;
    run_setting(1'b1, 1'b1, 10'd37, 16'd10240, 24'd118400, 150, 1'b0);

    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/lbev_pkg.sv
rtl/lbev_if.sv
rtl/lbev_ctrl.sv
rtl/lbev_dp.sv
rtl/lidar_points_to_bev_grid.sv
rtl/lbev_check.sv
tb/lidar_points_to_bev_grid_tb.sv
